### rtl/gtss_pkg.sv
`timescale 1ns / 1ps
package gtss_pkg;
  localparam logic [7:0] BLK_IMAGE   = 8'h2c;
  localparam logic [7:0] BLK_EXT     = 8'h21;
  localparam logic [7:0] BLK_TRAILER = 8'h3b;
  localparam logic [7:0] TBL_PRESENT = 8'h80;
  localparam logic [7:0] TBL_CODE    = 8'h07;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_EARLY    = 2'd2;

  localparam logic CFG_ACROSS = 1'b0;
  localparam logic CFG_DOWN   = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       stream_done;
  } res_t;

  function automatic logic [9:0] table_len(input logic [7:0] packed_b);
    logic [9:0] l;
    l = 10'd3 << ({1'b0, packed_b[2:0]} + 4'd1);
    return packed_b[7] ? l : 10'd0;
  endfunction
endpackage

### rtl/gtss_front.sv
`timescale 1ns / 1ps
module gtss_front #(
  parameter int GRID_LIMIT = 36
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [5:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_file_end,
  output logic              res_valid,
  output gtss_pkg::res_t    res,
  input  logic              q_full
);
  typedef enum logic [3:0] {
    PH_HEADER, PH_GCT, PH_BLOCK_ID, PH_DESC, PH_LCT, PH_LZW_MIN, PH_IMG_SIZE,
    PH_IMG_DATA, PH_EXT_LABEL, PH_EXT_SIZE, PH_EXT_DATA, PH_SKIP, PH_DONE
  } phase_t;

  localparam logic [5:0] LIMIT = 6'(GRID_LIMIT);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fc_r, fc_nxt;
  logic [9:0]  left_r, left_nxt;
  logic [5:0]  col_r, col_nxt, row_r, row_nxt;
  logic [15:0] mw_r, mw_nxt, mh_r, mh_nxt, tw_r, tw_nxt, th_r, th_nxt;
  logic [15:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [2:0]  mcode_r, mcode_nxt;
  logic        carry_r, carry_nxt;
  logic [5:0]  across_r, down_r, eff_a, eff_d;
  logic        first, last, ok_end, fire, emit;
  gtss_pkg::res_t r;
  logic [21:0] prod;
  logic [8:0]  sum;
  logic [15:0] offx_p, offy_p;

  assign in_stall = q_full;
  assign fire = in_valid && !q_full;

  always_comb begin
    eff_a = (across_r == 6'd0) ? 6'd1 : ((across_r > LIMIT) ? LIMIT : across_r);
    eff_d = (down_r == 6'd0) ? 6'd1 : ((down_r > LIMIT) ? LIMIT : down_r);
  end
  assign first = (col_r == 6'd0) && (row_r == 6'd0);
  assign last = ({1'b0, col_r} + 7'd1 >= {1'b0, eff_a}) &&
                ({1'b0, row_r} + 7'd1 >= {1'b0, eff_d});

  always_comb begin
    phase_nxt = phase_r; fc_nxt = fc_r; left_nxt = left_r;
    col_nxt = col_r; row_nxt = row_r; mw_nxt = mw_r; mh_nxt = mh_r;
    tw_nxt = tw_r; th_nxt = th_r; ox_nxt = ox_r; oy_nxt = oy_r;
    mcode_nxt = mcode_r; carry_nxt = carry_r;
    ok_end = 1'b0; emit = 1'b0;
    r = '{data_byte: in_data_byte, status: gtss_pkg::ST_OK, stream_done: 1'b0};
    prod = '0; sum = '0;
    offx_p = '0; offy_p = '0;
    case (phase_r)
      PH_HEADER: begin
        emit = first;
        if (fc_r == 4'd6) begin
          tw_nxt = {8'd0, in_data_byte};
          prod = 22'(in_data_byte * eff_a);
          r.data_byte = prod[7:0];
        end else if (fc_r == 4'd7) begin
          tw_nxt = {in_data_byte, tw_r[7:0]};
          prod = 22'(tw_nxt * eff_a);
          r.data_byte = prod[15:8];
        end else if (fc_r == 4'd8) begin
          th_nxt = {8'd0, in_data_byte};
          prod = 22'(in_data_byte * eff_d);
          r.data_byte = prod[7:0];
        end else if (fc_r == 4'd9) begin
          th_nxt = {in_data_byte, th_r[7:0]};
          prod = 22'(th_nxt * eff_d);
          r.data_byte = prod[15:8];
        end else if (fc_r == 4'd10) begin
          left_nxt = gtss_pkg::table_len(in_data_byte);
          if (first) begin
            mw_nxt = tw_r; mh_nxt = th_r;
            mcode_nxt = in_data_byte[2:0];
          end
        end else if (fc_r == 4'd12) begin
          r.data_byte = 8'd0;
        end
        if (fc_r >= 4'd12) begin
          fc_nxt = 4'd0;
          phase_nxt = (left_nxt != 10'd0) ? PH_GCT : PH_BLOCK_ID;
        end else begin
          fc_nxt = fc_r + 4'd1;
        end
      end
      PH_GCT: begin
        emit = first;
        if (left_r <= 10'd1) begin
          left_nxt = '0; phase_nxt = PH_BLOCK_ID;
        end else begin
          left_nxt = left_r - 10'd1;
        end
      end
      PH_BLOCK_ID: begin
        if (in_data_byte == gtss_pkg::BLK_IMAGE) begin
          emit = 1'b1; fc_nxt = 4'd0; phase_nxt = PH_DESC;
        end else if (in_data_byte == gtss_pkg::BLK_EXT) begin
          emit = last; phase_nxt = PH_EXT_LABEL;
        end else if (in_data_byte == gtss_pkg::BLK_TRAILER) begin
          if (!last) begin
            ok_end = 1'b1;
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_DESC: begin
        emit = 1'b1;
        if (fc_r == 4'd0 || fc_r == 4'd2) begin
          sum = {1'b0, in_data_byte} + {1'b0, (fc_r == 4'd0) ? ox_r[7:0] : oy_r[7:0]};
          carry_nxt = sum[8];
          r.data_byte = sum[7:0];
        end else if (fc_r == 4'd1 || fc_r == 4'd3) begin
          sum = {1'b0, in_data_byte} + {1'b0, (fc_r == 4'd1) ? ox_r[15:8] : oy_r[15:8]}
                + {8'd0, carry_r};
          carry_nxt = 1'b0;
          r.data_byte = sum[7:0];
        end
        if (fc_r >= 4'd8) begin
          fc_nxt = 4'd0;
          left_nxt = gtss_pkg::table_len(in_data_byte);
          phase_nxt = (left_nxt != 10'd0) ? PH_LCT : PH_LZW_MIN;
        end else begin
          fc_nxt = fc_r + 4'd1;
        end
      end
      PH_LCT: begin
        emit = 1'b1;
        if (left_r <= 10'd1) begin
          left_nxt = '0; phase_nxt = PH_LZW_MIN;
        end else begin
          left_nxt = left_r - 10'd1;
        end
      end
      PH_LZW_MIN: begin
        emit = 1'b1; phase_nxt = PH_IMG_SIZE;
      end
      PH_IMG_SIZE: begin
        emit = 1'b1;
        if (in_data_byte == 8'd0) begin
          phase_nxt = PH_BLOCK_ID;
        end else begin
          left_nxt = {2'd0, in_data_byte}; phase_nxt = PH_IMG_DATA;
        end
      end
      PH_IMG_DATA: begin
        emit = 1'b1;
        if (left_r <= 10'd1) begin
          left_nxt = '0; phase_nxt = PH_IMG_SIZE;
        end else begin
          left_nxt = left_r - 10'd1;
        end
      end
      PH_EXT_LABEL: begin
        emit = last; phase_nxt = PH_EXT_SIZE;
      end
      PH_EXT_SIZE: begin
        emit = last;
        if (in_data_byte == 8'd0) begin
          phase_nxt = PH_BLOCK_ID;
        end else begin
          left_nxt = {2'd0, in_data_byte}; phase_nxt = PH_EXT_DATA;
        end
      end
      PH_EXT_DATA: begin
        emit = last;
        if (left_r <= 10'd1) begin
          left_nxt = '0; phase_nxt = PH_EXT_SIZE;
        end else begin
          left_nxt = left_r - 10'd1;
        end
      end
      PH_SKIP: ok_end = 1'b1;
      default: ;
    endcase

    // tile header disagrees with the first tile
    if (phase_r == PH_HEADER && fc_r == 4'd10 && !first &&
        (tw_r != mw_r || th_r != mh_r || in_data_byte[2:0] != mcode_r)) begin
      emit = 1'b1;
      r = '{data_byte: gtss_pkg::BLK_TRAILER, status: gtss_pkg::ST_MISMATCH,
            stream_done: 1'b1};
      phase_nxt = PH_DONE;
    end else if (phase_r == PH_BLOCK_ID && in_data_byte == gtss_pkg::BLK_TRAILER && last) begin
      emit = 1'b1;
      r = '{data_byte: gtss_pkg::BLK_TRAILER, status: gtss_pkg::ST_OK, stream_done: 1'b1};
      phase_nxt = PH_DONE;
    end else if (phase_r != PH_DONE && in_file_end && !ok_end) begin
      emit = 1'b1;
      r = '{data_byte: gtss_pkg::BLK_TRAILER, status: gtss_pkg::ST_EARLY, stream_done: 1'b1};
      phase_nxt = PH_DONE;
    end else if (ok_end && in_file_end) begin
      // advance to the next tile
      if ({1'b0, col_r} + 7'd1 >= {1'b0, eff_a}) begin
        col_nxt = '0; row_nxt = row_r + 6'd1;
      end else begin
        col_nxt = col_r + 6'd1;
      end
      offx_p = 16'(col_nxt * mw_r);
      offy_p = 16'(row_nxt * mh_r);
      ox_nxt = offx_p; oy_nxt = offy_p;
      carry_nxt = 1'b0; fc_nxt = '0; left_nxt = '0; phase_nxt = PH_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; fc_r <= '0; left_r <= '0; col_r <= '0; row_r <= '0;
      mw_r <= '0; mh_r <= '0; tw_r <= '0; th_r <= '0; ox_r <= '0; oy_r <= '0;
      mcode_r <= '0; carry_r <= 1'b0; across_r <= 6'd1; down_r <= 6'd1;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gtss_pkg::CFG_ACROSS) across_r <= cfg_data;
        else down_r <= cfg_data;
      end
      res_valid <= fire && emit;
      if (fire) begin
        phase_r <= phase_nxt; fc_r <= fc_nxt; left_r <= left_nxt;
        col_r <= col_nxt; row_r <= row_nxt; mw_r <= mw_nxt; mh_r <= mh_nxt;
        tw_r <= tw_nxt; th_r <= th_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt;
        mcode_r <= mcode_nxt; carry_r <= carry_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res <= r;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |=> (phase_r == PH_DONE)) else $error("left done state");
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.stream_done |-> (phase_r == PH_DONE)) else $error("done without stop");
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DESC) |-> (fc_r <= 4'd8)) else $error("descriptor index overrun");
endmodule

### rtl/gtss_queue.sv
`timescale 1ns / 1ps
module gtss_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  input  gtss_pkg::res_t wr_data,
  output logic           almost_full,
  output logic           rd_valid,
  output gtss_pkg::res_t rd_data,
  input  logic           rd_stall
);
  gtss_pkg::res_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       rd;

  // one slot of headroom for the request already in the front register
  assign almost_full = (cnt_r + {2'd0, wr_valid}) >= 3'd3;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_data = mem_r[rp_r];
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_valid) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_valid} - {2'd0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    wr_valid |-> cnt_r < 3'd4) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    !wr_valid && !rd |=> $stable(cnt_r)) else $error("count drift");
endmodule

### rtl/gif_tile_stream_stitcher_unit.sv
`timescale 1ns / 1ps
// Merges the GIF files of a tile grid, fed byte by byte in row-major order,
// into one GIF stream. One input byte is taken per cycle; each gives at most
// one output byte, registered and then queued. A parse front end classifies
// the bytes; a four-entry queue decouples it from the output stall, so input
// is accepted every cycle unless three queue entries are taken or pending.
module gif_tile_stream_stitcher_unit #(
  parameter int GRID_LIMIT = 36
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_file_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_status,
  output logic       out_stream_done
);
  logic           res_valid, q_full;
  gtss_pkg::res_t res, q_data;

  gtss_front #(.GRID_LIMIT(GRID_LIMIT)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .in_data_byte, .in_file_end, .res_valid, .res, .q_full
  );

  gtss_queue u_queue (
    .clk, .rst_n, .wr_valid(res_valid), .wr_data(res), .almost_full(q_full),
    .rd_valid(out_valid), .rd_data(q_data), .rd_stall(out_stall)
  );

  assign out_out_byte = q_data.data_byte;
  assign out_status = q_data.status;
  assign out_stream_done = q_data.stream_done;
endmodule

### sim/gif_stitch_checker.sv
`timescale 1ns / 1ps
module gif_stitch_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_file_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_out_byte,
  input  logic [1:0] out_status,
  input  logic       out_stream_done,
  output int         errors,
  output int         pending,
  output int         bytes_checked,
  output logic [1:0] end_status
);

  typedef enum logic [3:0] {
    P_HDR, P_GCT, P_BID, P_DESC, P_LCT, P_LZW, P_ISZ, P_IDAT,
    P_EXTL, P_EXTS, P_EXTD, P_SKIP, P_DONE
  } phase_t;

  gtss_pkg::res_t merged_q[$];
  logic [5:0]  across, down;
  phase_t      phase;
  logic [3:0]  fcnt;
  logic [9:0]  left;
  logic [5:0]  col, row;
  logic [15:0] mw, mh, tw, th, ox, oy;
  logic [2:0]  mcode;
  logic        carry;
  logic [1:0]  err;
  gtss_pkg::res_t nxt;
  bit          have, ended;

  function automatic int unsigned grid_count(input logic [5:0] v);
    if (v == 0) return 1;
    if (v > 36) return 36;
    return v;
  endfunction

  function automatic logic [9:0] tbl_bytes(input logic [7:0] p);
    return p[7] ? (10'd3 << (p[2:0] + 1)) : 10'd0;
  endfunction

  task automatic emit(input logic [7:0] v);
    nxt = '{data_byte: v, status: gtss_pkg::ST_OK, stream_done: 1'b0};
    have = 1;
  endtask

  task automatic close_stream(input logic [1:0] code);
    err = code;
    phase = P_DONE;
    nxt = '{data_byte: gtss_pkg::BLK_TRAILER, status: code, stream_done: 1'b1};
    have = 1;
    ended = 1;
  endtask

  task automatic advance_tile(input int unsigned a);
    if (col + 1 >= a) begin
      col = 0;
      row = row + 1;
    end else begin
      col = col + 1;
    end
    ox = 16'(col * mw);
    oy = 16'(row * mh);
    carry = 0;
    fcnt = 0;
    left = 0;
    phase = P_HDR;
  endtask

  task automatic stitch_byte(input logic [7:0] b, input logic fe);
    int unsigned a, d, k;
    bit first, last, ok_end;
    logic [8:0] s;
    a = grid_count(across);
    d = grid_count(down);
    first = (col == 0 && row == 0);
    last = (col + 1 >= a) && (row + 1 >= d);
    ok_end = 0;
    have = 0;
    ended = 0;
    k = fcnt;
    case (phase)
      P_HDR: begin
        if (k == 6) begin
          tw = {8'h00, b};
          if (first) emit(8'(b * a));
        end else if (k == 7) begin
          tw[15:8] = b;
          if (first) emit(8'((32'(tw) * a) >> 8));
        end else if (k == 8) begin
          th = {8'h00, b};
          if (first) emit(8'(b * d));
        end else if (k == 9) begin
          th[15:8] = b;
          if (first) emit(8'((32'(th) * d) >> 8));
        end else if (k == 10) begin
          left = tbl_bytes(b);
          if (first) begin
            mw = tw;
            mh = th;
            mcode = b[2:0];
            emit(b);
          end else if (tw != mw || th != mh || b[2:0] != mcode) begin
            close_stream(gtss_pkg::ST_MISMATCH);
          end
        end else if (k == 12) begin
          if (first) emit(8'h00);
        end else begin
          if (first) emit(b);
        end
        if (!ended) begin
          if (k >= 12) begin
            fcnt = 0;
            phase = (left != 0) ? P_GCT : P_BID;
          end else begin
            fcnt = k + 1;
          end
        end
      end
      P_GCT: begin
        if (first) emit(b);
        if (left <= 1) begin
          left = 0;
          phase = P_BID;
        end else left--;
      end
      P_BID: begin
        if (b == gtss_pkg::BLK_IMAGE) begin
          emit(b);
          fcnt = 0;
          phase = P_DESC;
        end else if (b == gtss_pkg::BLK_EXT) begin
          if (last) emit(b);
          phase = P_EXTL;
        end else if (b == gtss_pkg::BLK_TRAILER) begin
          if (last) close_stream(gtss_pkg::ST_OK);
          else begin
            ok_end = 1;
            if (fe) advance_tile(a);
            else phase = P_SKIP;
          end
        end
      end
      P_DESC: begin
        if (k == 0 || k == 2) begin
          s = b + ((k == 0) ? ox[7:0] : oy[7:0]);
          carry = s[8];
          emit(s[7:0]);
        end else if (k == 1 || k == 3) begin
          s = b + ((k == 1) ? ox[15:8] : oy[15:8]) + carry;
          carry = 0;
          emit(s[7:0]);
        end else begin
          emit(b);
        end
        if (k >= 8) begin
          fcnt = 0;
          left = tbl_bytes(b);
          phase = (left != 0) ? P_LCT : P_LZW;
        end else fcnt = k + 1;
      end
      P_LCT: begin
        emit(b);
        if (left <= 1) begin
          left = 0;
          phase = P_LZW;
        end else left--;
      end
      P_LZW: begin
        emit(b);
        phase = P_ISZ;
      end
      P_ISZ: begin
        emit(b);
        if (b == 0) phase = P_BID;
        else begin
          left = b;
          phase = P_IDAT;
        end
      end
      P_IDAT: begin
        emit(b);
        if (left <= 1) begin
          left = 0;
          phase = P_ISZ;
        end else left--;
      end
      P_EXTL: begin
        if (last) emit(b);
        phase = P_EXTS;
      end
      P_EXTS: begin
        if (last) emit(b);
        if (b == 0) phase = P_BID;
        else begin
          left = b;
          phase = P_EXTD;
        end
      end
      P_EXTD: begin
        if (last) emit(b);
        if (left <= 1) begin
          left = 0;
          phase = P_EXTS;
        end else left--;
      end
      P_SKIP: begin
        ok_end = 1;
        if (fe) advance_tile(a);
      end
      default: ended = 1;
    endcase
    if (!ended && fe && !ok_end) close_stream(gtss_pkg::ST_EARLY);
    if (have) merged_q.push_back(nxt);
  endtask

  always @(posedge clk) begin
    gtss_pkg::res_t want;
    if (!rst_n) begin
      merged_q.delete();
      across = 1;
      down = 1;
      phase = P_HDR;
      fcnt = 0;
      left = 0;
      col = 0;
      row = 0;
      mw = 0;
      mh = 0;
      mcode = 0;
      tw = 0;
      th = 0;
      ox = 0;
      oy = 0;
      carry = 0;
      err = 0;
      errors <= 0;
      bytes_checked <= 0;
      end_status <= gtss_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gtss_pkg::CFG_ACROSS) across = cfg_data;
        else down = cfg_data;
      end
      if (out_valid && !out_stall) begin
        bytes_checked <= bytes_checked + 1;
        if (out_stream_done) end_status <= out_status;
        if (merged_q.size() == 0) begin
          $display("%0t: unexpected output byte %02h status %0d done %0b", $time,
                   out_out_byte, out_status, out_stream_done);
          errors <= errors + 1;
        end else begin
          want = merged_q.pop_front();
          if (want.data_byte !== out_out_byte || want.status !== out_status ||
              want.stream_done !== out_stream_done) begin
            $display("%0t: expected byte %02h status %0d done %0b, got %02h %0d %0b",
                     $time, want.data_byte, want.status, want.stream_done,
                     out_out_byte, out_status, out_stream_done);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) stitch_byte(in_data_byte, in_file_end);
    end
    pending <= merged_q.size();
  end

endmodule

### sim/gif_tile_stream_stitcher_unit_tb.sv
`timescale 1ns / 1ps
module gif_tile_stream_stitcher_unit_tb;

  localparam int LIMIT = 400000;
  localparam int MODE_NORMAL = 0;
  localparam int MODE_MISMATCH = 1;
  localparam int MODE_EARLY = 2;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [5:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_file_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_out_byte;
  logic [1:0] out_status;
  logic       out_stream_done;
  int         errors, pending, bytes_checked;
  logic [1:0] end_status;

  int          cycles = 0;
  int          send_idle = 0, recv_idle = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  int          sent = 0, tiles = 0, early_left = 0;
  bit          stopped = 0;
  logic [15:0] mw, mh;
  logic [2:0]  mcode;

  gif_tile_stream_stitcher_unit dut (.*);

  gif_stitch_checker chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic fe);
    if (stopped) return;
    if (early_left > 0) begin
      early_left--;
      if (early_left == 0) begin
        fe = 1'b1;
        stopped = 1;
      end
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_file_end <= fe;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic put_subblocks();
    int m, sz;
    m = $urandom_range(0, 3);
    repeat (m) begin
      sz = ($urandom_range(15) == 0) ? 255 : $urandom_range(1, 12);
      put_byte(8'(sz), 1'b0);
      repeat (sz) put_byte(8'($urandom), 1'b0);
    end
    put_byte(8'h00, 1'b0);
  endtask

  task automatic send_tile(input bit is_first, input bit is_last, input int mode);
    logic [15:0] tw, th;
    logic [2:0]  tc;
    logic [7:0]  p, id;
    bit          gct, te;
    int          nblk, kind;
    if (is_first) begin
      mw = 16'($urandom);
      mh = 16'($urandom);
      mcode = 3'($urandom_range(7));
    end
    tw = mw;
    th = mh;
    tc = mcode;
    if (mode == MODE_MISMATCH) begin
      case ($urandom_range(2))
        0: tw = tw ^ (16'd1 << $urandom_range(15));
        1: th = th ^ (16'd1 << $urandom_range(15));
        default: tc = tc + 3'd1;
      endcase
    end
    if (mode == MODE_EARLY) early_left = $urandom_range(2, 60);
    repeat (6) put_byte(8'($urandom), 1'b0);
    put_byte(tw[7:0], 1'b0);
    put_byte(tw[15:8], 1'b0);
    put_byte(th[7:0], 1'b0);
    put_byte(th[15:8], 1'b0);
    gct = (tc <= 2) ? ($urandom_range(1) == 1) : ($urandom_range(7) == 0);
    p = {gct, 4'($urandom), tc};
    put_byte(p, 1'b0);
    if (mode == MODE_MISMATCH) stopped = 1;
    put_byte(8'($urandom), 1'b0);
    put_byte(8'($urandom), 1'b0);
    if (gct) repeat (3 << (tc + 1)) put_byte(8'($urandom), 1'b0);
    nblk = $urandom_range(1, 3);
    repeat (nblk) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        put_byte(gtss_pkg::BLK_IMAGE, 1'b0);
        repeat (8) put_byte(8'($urandom), 1'b0);
        p = 8'($urandom);
        if ($urandom_range(5) != 0) p[7] = 1'b0;
        else if ($urandom_range(3) != 0) p[2:0] = 3'($urandom_range(2));
        put_byte(p, 1'b0);
        if (p[7]) repeat (3 << (p[2:0] + 1)) put_byte(8'($urandom), 1'b0);
        put_byte(8'($urandom_range(2, 8)), 1'b0);
        put_subblocks();
      end else if (kind <= 7) begin
        put_byte(gtss_pkg::BLK_EXT, 1'b0);
        put_byte(8'($urandom), 1'b0);
        put_subblocks();
      end else begin
        do id = 8'($urandom);
        while (id == gtss_pkg::BLK_IMAGE || id == gtss_pkg::BLK_EXT ||
               id == gtss_pkg::BLK_TRAILER);
        put_byte(id, 1'b0);
      end
    end
    te = $urandom_range(1);
    put_byte(gtss_pkg::BLK_TRAILER, te);
    if (!te && !is_last) begin
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom), 1'b0);
      put_byte(8'($urandom), 1'b1);
    end
    tiles++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [5:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = gtss_pkg::CFG_ACROSS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_file_end = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 31;
    recv_idle = 48;
    write_reg(gtss_pkg::CFG_ACROSS, 6'd63);
    write_reg(gtss_pkg::CFG_DOWN, 6'd36);
    send_tile(1'b1, 1'b0, MODE_NORMAL);
    while (sent < 1000 && tiles < 30) begin
      if (sent > 740) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (sent > 370) begin
        send_idle = 48;
        recv_idle = 31;
      end
      if (tiles == 4) hold_req = 1;
      if (tiles == 8) begin
        settle();
        write_reg(gtss_pkg::CFG_ACROSS, 6'd0);
        write_reg(gtss_pkg::CFG_DOWN, 6'($urandom_range(33, 36)));
      end
      if (tiles == 14) begin
        settle();
        write_reg(gtss_pkg::CFG_ACROSS, 6'($urandom_range(1, 36)));
      end
      send_tile(1'b0, 1'b0, MODE_NORMAL);
    end
    settle();
    write_reg(gtss_pkg::CFG_ACROSS, 6'd0);
    write_reg(gtss_pkg::CFG_DOWN, 6'd0);
    send_tile(1'b0, 1'b1, $urandom_range(2));
    stopped = 0;
    early_left = 0;
    repeat (3) put_byte(8'($urandom), 1'($urandom_range(1)));
    settle();
    repeat (20) @(posedge clk);
    $display("run fed %0d bytes in %0d tiles, checked %0d merged bytes, end status %0d",
             sent, tiles, bytes_checked, end_status);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/gtss_pkg.sv
rtl/gtss_front.sv
rtl/gtss_queue.sv
rtl/gif_tile_stream_stitcher_unit.sv
sim/gif_stitch_checker.sv
sim/gif_tile_stream_stitcher_unit_tb.sv
